[hdl/l1p_pkg.sv]
package l1p_pkg;

  // fixed-point formats
  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned XW        = 32;              // x_value width, Q1.FRAC_BITS
  localparam int unsigned PW        = FRAC_BITS + 1;   // magnitude of x and of its powers
  localparam int unsigned AW        = FRAC_BITS + 10;  // accumulator, Q9.FRAC_BITS
  localparam int unsigned TCW       = 16;              // term_count register width

  localparam logic [TCW-1:0] TERM_COUNT_RESET = TCW'(20000);
  localparam int unsigned    MAX_TERMS_DEF    = 65535;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture x, clear accumulator, first term
    logic div_init;  // start dividing the current power by k
    logic div_step;  // one quotient bit
    logic accum;     // add or subtract the quotient
    logic mul;       // next power of x, advance k
  } l1p_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic n_zero;     // no terms to sum
    logic last_term;  // current k is the final term
  } l1p_sts_t;

endpackage

[hdl/l1p_ctrl.sv]
module l1p_ctrl
  import l1p_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     done_o,
  output l1p_cmd_t cmd_o,
  input  l1p_sts_t sts_i
);

  localparam int unsigned CW = $clog2(PW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TERM,
    ST_DIV,
    ST_ACC,
    ST_MUL,
    ST_DONE
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q;

  // state and bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start) state_q <= ST_TERM;
        end
        ST_TERM: begin
          if (sts_i.n_zero) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q   <= CW'(PW - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= ST_ACC;
        end
        ST_ACC: begin
          state_q <= sts_i.last_term ? ST_DONE : ST_MUL;
        end
        ST_MUL:  state_q <= ST_TERM;
        ST_DONE: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && start;
    cmd_o.div_init = (state_q == ST_TERM) && !sts_i.n_zero;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.accum    = (state_q == ST_ACC);
    cmd_o.mul      = (state_q == ST_MUL);
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

[hdl/l1p_datapath.sv]
module l1p_datapath
  import l1p_pkg::*;
#(
  parameter int unsigned KW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  l1p_cmd_t             cmd_i,
  output l1p_sts_t             sts_o,
  input  logic signed [XW-1:0] x_value_i,
  input  logic [KW-1:0]        n_limit_i,
  output logic signed [AW-1:0] log_result_o,
  output logic                 overflow_o
);

  localparam logic signed [XW-1:0] X_ONE   = XW'(64'd1 << FRAC_BITS);
  localparam logic signed [XW-1:0] X_M_ONE = -X_ONE;
  localparam logic [AW-1:0]        ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic [AW-1:0]        ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  logic [PW-1:0]        x_mag_q, p_mag_q, quo_q;
  logic                 x_neg_q;
  logic [KW-1:0]        k_q, n_q, rem_q;
  logic signed [AW-1:0] acc_q;
  logic                 ovf_q;

  logic signed [XW-1:0] x_clamp;
  logic [XW-1:0]        x_abs;
  logic [2*PW-1:0]      prod;
  logic [KW:0]          trial_rem, trial_diff;
  logic                 trial_ge;
  logic [AW:0]          acc_ext, term_ext, sum;
  logic                 term_neg;

  // clamp x to [-1, 1] and split sign and magnitude
  always_comb begin
    if (x_value_i > X_ONE) begin
      x_clamp = X_ONE;
    end else if (x_value_i < X_M_ONE) begin
      x_clamp = X_M_ONE;
    end else begin
      x_clamp = x_value_i;
    end
    x_abs = x_clamp[XW-1] ? XW'(-x_clamp) : XW'(x_clamp);
  end

  // next power, truncated
  assign prod = (2*PW)'(p_mag_q) * (2*PW)'(x_mag_q);

  // restoring divide, one quotient bit per step
  assign trial_rem  = {rem_q, quo_q[PW-1]};
  assign trial_diff = trial_rem - {1'b0, k_q};
  assign trial_ge   = (trial_rem >= {1'b0, k_q});

  // signed add of the term; negative x makes every term negative
  assign term_neg = x_neg_q | ~k_q[0];
  assign acc_ext  = {acc_q[AW-1], acc_q};
  assign term_ext = (AW+1)'(quo_q);
  assign sum      = term_neg ? (acc_ext - term_ext) : (acc_ext + term_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.load) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.accum) begin
      if (sum[AW] != sum[AW-1]) begin
        acc_q <= sum[AW] ? ACC_MIN : ACC_MAX;
        ovf_q <= 1'b1;
      end else begin
        acc_q <= sum[AW-1:0];
      end
    end
  end

  // operand and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_mag_q <= x_abs[PW-1:0];
      p_mag_q <= x_abs[PW-1:0];
      x_neg_q <= x_clamp[XW-1];
      k_q     <= KW'(1);
      n_q     <= n_limit_i;
    end
    if (cmd_i.mul) begin
      p_mag_q <= prod[FRAC_BITS +: PW];
      k_q     <= k_q + 1'b1;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= p_mag_q;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_diff[KW-1:0] : trial_rem[KW-1:0];
      quo_q <= {quo_q[PW-2:0], trial_ge};
    end
  end

  assign sts_o.n_zero    = (n_q == '0);
  assign sts_o.last_term = (k_q == n_q);

  assign log_result_o = acc_q;
  assign overflow_o   = ovf_q;

endmodule

[hdl/log1p_series_evaluator.sv]
// channel  | ports                                  | request taken when
// ---------+----------------------------------------+----------------------------
// input    | start, x_value_i                       | start high, busy low
// result   | done_o, log_result_o, overflow_o       | done_o high (one cycle)
// config   | cfg_valid_i, cfg_ready_o, cfg_data_i   | cfg_valid_i and cfg_ready_o
//
// an item with N terms: per term the datapath sets up the divide, runs a
// bit-serial divide by k and accumulates, plus a multiply for the next power
// between terms; for N = 0 the controller goes from ST_TERM straight to
// ST_DONE. busy stays high through the done_o cycle. reset clears the
// controller and loads term_count with 20000. the receiver cannot stall; the
// result is valid only in the done_o cycle.
module log1p_series_evaluator
  import l1p_pkg::*;
#(
  parameter int unsigned MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [XW-1:0] x_value_i,
  output logic                 done_o,
  output logic signed [AW-1:0] log_result_o,
  output logic                 overflow_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [TCW-1:0]       cfg_data_i
);

  localparam int unsigned KW = $clog2(MAX_TERMS + 1);

  logic [TCW-1:0] term_count_q;
  logic [31:0]    n_wide;
  logic [KW-1:0]  n_limit;
  l1p_cmd_t       cmd;
  l1p_sts_t       sts;

  // term count register
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= TERM_COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      term_count_q <= cfg_data_i;
    end
  end

  // limit the term count to MAX_TERMS
  assign n_wide  = (32'(term_count_q) > 32'(MAX_TERMS)) ? 32'(MAX_TERMS) : 32'(term_count_q);
  assign n_limit = n_wide[KW-1:0];

  l1p_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  l1p_datapath #(
    .KW (KW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .x_value_i    (x_value_i),
    .n_limit_i    (n_limit),
    .log_result_o (log_result_o),
    .overflow_o   (overflow_o)
  );

endmodule

[hdl/l1p_checker.sv]
module l1p_checker
  import l1p_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input logic signed [AW-1:0] log_result_o,
  input logic                 overflow_o,
  input logic                 cfg_ready_o
);

  // an accepted request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // a result only comes while an item is in flight, and it is known
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o |-> busy && !$isunknown({log_result_o, overflow_o}))
    else $error("result strobe while idle or unknown result");

  // the strobe lasts exactly one cycle and ends the item
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  // busy only drops right after a result
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy) |-> $past(done_o))
    else $error("item ended without a result");

  // no configuration while an item runs
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> !cfg_ready_o)
    else $error("config accepted while busy");

endmodule

bind log1p_series_evaluator l1p_checker u_l1p_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .log_result_o (log_result_o),
  .overflow_o   (overflow_o),
  .cfg_ready_o  (cfg_ready_o)
);
